// ===== sv/mfd_pkg.sv =====
// Package for the marker frame deframer: frame geometry, register indexes,
// reset values and the structs passed between modules. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfd_pkg;

    localparam int FRAME_LENGTH = 7;
    localparam int PAYLOAD_LEN  = 4;
    localparam int POS_W        = 3;
    localparam int BYTE_W       = 8;
    localparam int WORD_W       = PAYLOAD_LEN * BYTE_W;
    localparam int CFG_IDX_W    = 1;

    // frame positions: 0 is the start marker, 1..4 payload, then checksum, then end
    localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
    localparam logic [POS_W-1:0] POS_PLAST = POS_W'(PAYLOAD_LEN);
    localparam logic [POS_W-1:0] POS_CHECK = POS_W'(FRAME_LENGTH - 2);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_LENGTH - 1);
    localparam logic [POS_W-1:0] POS_IDLE  = '0;

    localparam logic [BYTE_W-1:0] START_RESET = 8'h3C;
    localparam logic [BYTE_W-1:0] END_RESET   = 8'h3E;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START = 1'b0,
        CFG_END   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] payload;
        logic              ok;
    } t_result;

    typedef struct packed {
        logic             in_frame;
        logic [POS_W-1:0] pos;
    } t_frame_status;

endpackage

`default_nettype wire

// ===== sv/mfd_frame.sv =====
// Frame tracker: position counter, payload and checksum store, result build.
// Depends on mfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfd_frame import mfd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic [BYTE_W-1:0] i_start_byte,
    input  wire logic [BYTE_W-1:0] i_end_byte,
    output t_result                o_res,
    output t_frame_status          o_status
);

    logic                          r_in_frame, n_in_frame;
    logic [POS_W-1:0]              r_pos, n_pos;
    logic [PAYLOAD_LEN-1:0][BYTE_W-1:0] r_payload;
    logic [BYTE_W-1:0]             r_check;
    logic [BYTE_W-1:0]             w_xor;
    logic                          w_is_payload;
    logic                          w_is_check;
    logic [1:0]                    w_slot;

    assign w_is_payload = (r_pos >= POS_FIRST) && (r_pos <= POS_PLAST);
    assign w_is_check   = (r_pos == POS_CHECK);
    assign w_slot       = 2'(r_pos - POS_FIRST);

    always_comb begin
        w_xor = '0;
        for (int k = 0; k < PAYLOAD_LEN; k++) begin
            w_xor = w_xor ^ r_payload[k];
        end
    end

    always_comb begin
        n_in_frame    = r_in_frame;
        n_pos         = r_pos;
        o_res.valid   = 1'b0;
        o_res.payload = r_payload;
        o_res.ok      = (w_xor == r_check);
        if (i_adv) begin
            if (!r_in_frame) begin
                if (i_byte == i_start_byte) begin
                    n_in_frame = 1'b1;
                    n_pos      = POS_FIRST;
                end
            end else if (w_is_payload || w_is_check) begin
                n_pos = r_pos + POS_W'(1);
            end else begin
                // last byte; any stray position closes the frame too
                n_in_frame  = 1'b0;
                n_pos       = POS_IDLE;
                o_res.valid = (r_pos == POS_LAST) && (i_byte == i_end_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= POS_IDLE;
        end else begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && r_in_frame && w_is_payload) begin
            r_payload[w_slot] <= i_byte;
        end
        if (i_adv && r_in_frame && w_is_check) begin
            r_check <= i_byte;
        end
    end

    assign o_status.in_frame = r_in_frame;
    assign o_status.pos      = r_pos;

endmodule

`default_nettype wire

// ===== sv/mfd_out_reg.sv =====
// Result register for the output channel; holds a beat while stalled.
// Depends on mfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfd_out_reg import mfd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  t_result                i_res,
    input  wire logic              i_stall,
    output logic                   o_ready,
    output logic                   o_valid,
    output logic [WORD_W-1:0]      o_payload,
    output logic                   o_ok
);

    logic              r_valid;
    logic [WORD_W-1:0] r_payload;
    logic              r_ok;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load && i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load && i_res.valid) begin
            r_payload <= i_res.payload;
            r_ok      <= i_res.ok;
        end
    end

    assign o_valid   = r_valid;
    assign o_payload = r_payload;
    assign o_ok      = r_ok;

endmodule

`default_nettype wire

// ===== sv/marker_frame_deframer_xor_check.sv =====
// Top level of the marker frame deframer with XOR check: marker registers,
// input register, frame tracker and result register. Depends on mfd_pkg.
//
//  channel   direction  handshake               payload
//  rx        in         i_rx_valid/o_rx_stall   i_rx_byte[7:0]
//  res       out        o_res_valid/i_res_stall o_payload_bits[31:0], o_check_ok
//  cfg       in         i_cfg_we                i_cfg_index, i_cfg_wdata[7:0]
//
// One byte per cycle sustained while the result channel is not stalled. An accepted
// byte is held in the input register, is parsed, and its result (if any) is
// registered in the result register and driven on the result port from there.
// Synchronous active-low reset: idle, no frame open, markers 0x3C / 0x3E.
// A stalled result holds; input stalls only once the input register is full too.
`timescale 1ns / 1ps
`default_nettype none

module marker_frame_deframer_xor_check import mfd_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_rx_valid,
    output logic                      o_rx_stall,
    input  wire logic [BYTE_W-1:0]    i_rx_byte,
    output logic                      o_res_valid,
    input  wire logic                 i_res_stall,
    output logic [WORD_W-1:0]         o_payload_bits,
    output logic                      o_check_ok,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BYTE_W-1:0]    i_cfg_wdata
);

    logic [BYTE_W-1:0] r_start_byte;
    logic [BYTE_W-1:0] r_end_byte;
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              w_out_ready;
    logic              w_adv;
    t_result           w_res;
    t_frame_status     w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_RESET;
            r_end_byte   <= END_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_START: r_start_byte <= i_cfg_wdata;
                CFG_END:   r_end_byte   <= i_cfg_wdata;
                default:   ;
            endcase
        end
    end

    assign w_adv      = r_in_vld && w_out_ready;
    assign o_rx_stall = r_in_vld && !w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_rx_stall) begin
            r_in_vld <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_rx_stall && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    mfd_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_byte       (r_in_byte),
        .i_start_byte (r_start_byte),
        .i_end_byte   (r_end_byte),
        .o_res        (w_res),
        .o_status     (w_status)
    );

    mfd_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_adv),
        .i_res     (w_res),
        .i_stall   (i_res_stall),
        .o_ready   (w_out_ready),
        .o_valid   (o_res_valid),
        .o_payload (o_payload_bits),
        .o_ok      (o_check_ok)
    );

    // idle means position zero; inside a frame the position never wraps
    a_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_status.in_frame |-> (w_status.pos == POS_IDLE))
        else $error("position not cleared while idle");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.in_frame |-> (w_status.pos >= POS_FIRST && w_status.pos <= POS_LAST))
        else $error("frame position out of range");

    // a result closes the frame and lands in the output register
    a_res_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |=> (!w_status.in_frame && o_res_valid))
        else $error("result did not close frame or reach output");

    a_res_only_on_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> (w_adv && $past(w_status.pos) != POS_LAST || w_status.pos == POS_LAST))
        else $error("result raised away from the last byte");

endmodule

`default_nettype wire

// ===== dv/mfd_deframe_check.sv =====
// Watches the rx, res and cfg channels of the marker frame deframer, predicts each
// decoded frame and compares the results in order. Depends on mfd_pkg.
`timescale 1ns / 1ps

module mfd_deframe_check import mfd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rx_valid,
    input  logic                 i_rx_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  logic [WORD_W-1:0]    i_payload_bits,
    input  logic                 i_check_ok,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_wdata,
    output int                   o_mismatches,
    output int                   o_outstanding
);

    typedef struct packed {
        logic [WORD_W-1:0] payload;
        logic              ok;
    } t_frame_word;

    logic              in_frame;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] data_bytes [PAYLOAD_LEN];
    logic [BYTE_W-1:0] chk_byte;
    logic [BYTE_W-1:0] start_mark;
    logic [BYTE_W-1:0] end_mark;
    t_frame_word       expected_frames [$];
    t_frame_word       head;
    int                mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task take_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] x;
        t_frame_word       w;
        if (!in_frame) begin
            if (b == start_mark) begin
                in_frame = 1'b1;
                pos      = POS_FIRST;
            end
        end else if (pos >= POS_FIRST && pos <= POS_PLAST) begin
            data_bytes[pos - POS_FIRST] = b;
            pos = pos + 1'b1;
        end else if (pos == POS_CHECK) begin
            chk_byte = b;
            pos      = pos + 1'b1;
        end else begin
            if (pos == POS_LAST && b == end_mark) begin
                x = data_bytes[0] ^ data_bytes[1] ^ data_bytes[2] ^ data_bytes[3];
                w.payload = {data_bytes[3], data_bytes[2], data_bytes[1], data_bytes[0]};
                w.ok      = (x == chk_byte);
                expected_frames.insert(expected_frames.size(), w);
            end
            in_frame = 1'b0;
            pos      = POS_IDLE;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_frame   = 1'b0;
            pos        = POS_IDLE;
            start_mark = START_RESET;
            end_mark   = END_RESET;
            expected_frames.delete();
        end else begin
            // register write lands before a byte taken on the same edge is parsed
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_START: start_mark = i_cfg_wdata;
                    CFG_END:   end_mark   = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_res_valid && !i_res_stall) begin
                if (expected_frames.size() == 0) begin
                    $display("%0t: result with none expected: payload_bits %h check_ok %b",
                             $time, i_payload_bits, i_check_ok);
                    mismatch_count++;
                end else begin
                    head = expected_frames.pop_front();
                    if (head.payload !== i_payload_bits) begin
                        $display("%0t: payload_bits expected %h actual %h",
                                 $time, head.payload, i_payload_bits);
                        mismatch_count++;
                    end
                    if (head.ok !== i_check_ok) begin
                        $display("%0t: check_ok expected %b actual %b",
                                 $time, head.ok, i_check_ok);
                        mismatch_count++;
                    end
                end
            end
            if (i_rx_valid && !i_rx_stall)
                take_byte(i_rx_byte);
        end
        o_outstanding <= expected_frames.size();
    end

endmodule

// ===== dv/marker_frame_deframer_xor_check_test.sv =====
// Testbench top for the marker frame deframer: drives byte stimulus, marker
// register writes and result stalls. Depends on mfd_pkg, mfd_deframe_check and the DUT top.
`timescale 1ns / 1ps

module marker_frame_deframer_xor_check_test;
    import mfd_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 8;
    localparam int FRAMES_PER = 11;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_rx_valid  = 1'b0;
    logic                 o_rx_stall;
    logic [BYTE_W-1:0]    i_rx_byte   = '0;
    logic                 o_res_valid;
    logic                 i_res_stall = 1'b0;
    logic [WORD_W-1:0]    o_payload_bits;
    logic                 o_check_ok;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_START;
    logic [BYTE_W-1:0]    i_cfg_wdata = '0;

    int                   mismatches;
    int                   outstanding;
    int                   idle_cycles = 0;
    bit                   quiet       = 1'b0;
    logic [BYTE_W-1:0]    cur_start   = START_RESET;
    logic [BYTE_W-1:0]    cur_end     = END_RESET;

    marker_frame_deframer_xor_check u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_stall     (o_rx_stall),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .o_payload_bits (o_payload_bits),
        .o_check_ok     (o_check_ok),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    mfd_deframe_check u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .i_rx_stall     (o_rx_stall),
        .i_rx_byte      (i_rx_byte),
        .i_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .i_payload_bits (o_payload_bits),
        .i_check_ok     (o_check_ok),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_res_stall <= !quiet && ($urandom_range(99) < 13);
    end

    // stall watchdog: any beat on either channel restarts the count
    always @(posedge i_clk) begin
        if ((i_rx_valid && !o_rx_stall) || (o_res_valid && !i_res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL marker_frame_deframer_xor_check");
            $finish;
        end
    end

    // mostly random, with markers and all-zero/all-one bytes thrown in often
    function automatic logic [BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(15);
        case (r)
            0, 1:    return cur_start;
            2, 3:    return cur_end;
            4:       return 8'h00;
            5:       return 8'hFF;
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (!quiet && $urandom_range(99) < 15) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_rx_stall) @(posedge i_clk);
    endtask

    task automatic send_frame();
        logic [BYTE_W-1:0] d [PAYLOAD_LEN];
        logic [BYTE_W-1:0] x;
        x = '0;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            d[i] = pick_byte();
            x    = x ^ d[i];
        end
        send_byte(cur_start);
        for (int i = 0; i < PAYLOAD_LEN; i++)
            send_byte(d[i]);
        send_byte(($urandom_range(99) < 70) ? x : pick_byte());
        send_byte(($urandom_range(99) < 85) ? cur_end : pick_byte());
    endtask

    task automatic run_traffic(input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 75) begin
                send_frame();
            end else if (r < 90) begin
                repeat ($urandom_range(1, 3)) send_byte(pick_byte());
            end else begin
                // cut-short frame: whatever follows is taken as its data
                send_byte(cur_start);
                repeat ($urandom_range(1, 5)) send_byte(pick_byte());
            end
        end
    endtask

    // drain: every expected result back, then time for a dropped frame to clear
    task automatic drain();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_markers(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_START;
        i_cfg_wdata <= s;
        @(posedge i_clk);
        i_cfg_index <= CFG_END;
        i_cfg_wdata <= e;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_start    = s;
        cur_end      = e;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset markers: idle junk, good frame with markers in the
        // data, bad last byte, bad checksum
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h3C);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h3C);
        send_byte(8'h3E);
        send_byte(8'hFD);
        send_byte(8'h3E);
        send_byte(8'h3C);
        send_byte(8'hFF);
        send_byte(8'h3E);
        send_byte(8'h3C);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h3D);
        send_byte(8'h3C);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'h3E);
        run_traffic(FRAMES_PER);
        drain();

        set_markers(8'h00, 8'hFF);
        quiet <= 1'b1;
        run_traffic(FRAMES_PER);
        drain();
        quiet <= 1'b0;

        set_markers(8'hFF, 8'h00);
        run_traffic(FRAMES_PER);
        drain();

        set_markers(8'h5A, 8'h5A);
        run_traffic(FRAMES_PER);
        drain();

        set_markers(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
        run_traffic(FRAMES_PER);
        drain();

        set_markers(START_RESET, END_RESET);
        run_traffic(FRAMES_PER);
        drain();

        if (mismatches == 0)
            $display("PASS marker_frame_deframer_xor_check");
        else
            $display("FAIL marker_frame_deframer_xor_check");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mfd_pkg.sv
sv/mfd_frame.sv
sv/mfd_out_reg.sv
sv/marker_frame_deframer_xor_check.sv
dv/mfd_deframe_check.sv
dv/marker_frame_deframer_xor_check_test.sv
